### hw/rtl/ecs_pkg.sv
// Package for the extent chunk splitter: payload structs, sequencer state,
// register map and the shared-adder operand bundle.
// No dependencies; every other file of the block imports it.
package ecs_pkg;

  // Chunk boundary in sectors is 2^CHUNK_SHIFT (valid from 12 to 16).
  localparam int CHUNK_SHIFT   = 12;
  localparam int CHUNK_SECTORS = 1 << CHUNK_SHIFT;
  localparam int SECTOR_SHIFT  = 9;
  localparam int MAX_CMDS      = 64;

  localparam int ADDR_W   = 48;
  localparam int LEN_W    = 27;
  localparam int LBA_W    = 39;
  localparam int CNT_W    = 17;
  localparam int PROC_W   = 49;
  localparam int ALU_W    = 50;
  localparam int REM_W    = LEN_W - SECTOR_SHIFT;
  localparam int CMD_W    = $clog2(MAX_CMDS);
  localparam int EX_W     = PROC_W - SECTOR_SHIFT;
  localparam int PADDR_W  = 4;
  localparam int PDATA_W  = 64;

  typedef struct packed {
    logic [ADDR_W-1:0] extent_logical;
    logic [ADDR_W-1:0] extent_physical;
    logic [LEN_W-1:0]  extent_bytes;
    logic              first_extent;
  } ecs_in_t;

  typedef struct packed {
    logic [LBA_W-1:0] start_lba;
    logic [CNT_W-1:0] num_sectors;
    logic             extent_end;
    logic             request_done;
  } ecs_out_t;

  // Register index, taken from paddr bit 3 (registers sit at byte 0 and 8).
  typedef enum logic {
    REG_START_OFFSET   = 1'b0,
    REG_REQUEST_LENGTH = 1'b1
  } ecs_reg_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SKIP,
    S_EFF,
    S_ADDR,
    S_CHUNK,
    S_CHECK
  } ecs_state_e;

  typedef struct packed {
    logic [ALU_W-1:0] a;
    logic [ALU_W-1:0] b;
    logic             sub;
  } ecs_alu_op_t;

  typedef struct packed {
    logic     valid;
    ecs_out_t data;
  } ecs_emit_t;

endpackage

### hw/rtl/extent_chunk_splitter_unit.sv
// Top level of the extent chunk splitter: configuration registers, result
// register, and the sequencer with its shared adder.
// Depends on ecs_pkg, ecs_alu and ecs_seq.

// The block takes one extent request at a time and is not ready again until
// it has issued every command of that extent. A command waits in its check
// step until the result register is free. An extent that yields nothing
// passes through setup alone, and one arriving after the request is
// satisfied (not a first extent) skips setup. All wide arithmetic goes
// through a single 50-bit adder/subtractor: three setup steps per extent,
// then one add and one compare per command. Commands leave through a result
// register, so the next command is computed while the previous one waits.
// Registers start_offset and request_length sit at byte 0 and 8 of the
// 64-bit port.
module extent_chunk_splitter_unit (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  output logic                           in_ready_o,
  input  ecs_pkg::ecs_in_t               in_data_i,
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output ecs_pkg::ecs_out_t              out_data_o,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [ecs_pkg::PADDR_W-1:0]    paddr,
  input  logic [ecs_pkg::PDATA_W-1:0]    pwdata,
  output logic [ecs_pkg::PDATA_W-1:0]    prdata,
  output logic                           pready
);
  import ecs_pkg::*;

  logic [ADDR_W-1:0] start_offset_q;
  logic [ADDR_W-1:0] request_length_q;
  logic              out_valid_q;
  ecs_out_t          out_q;
  ecs_emit_t         emit;
  ecs_alu_op_t       alu_op;
  logic [ALU_W-1:0]  alu_res;
  logic              out_free;
  ecs_reg_e          reg_sel;

  assign pready   = 1'b1;
  assign reg_sel  = ecs_reg_e'(paddr[3]);
  assign out_free = !out_valid_q || out_ready_i;

  always_comb begin
    unique case (reg_sel)
      REG_START_OFFSET:   prdata = PDATA_W'(start_offset_q);
      REG_REQUEST_LENGTH: prdata = PDATA_W'(request_length_q);
      default:            prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start_offset_q   <= '0;
      request_length_q <= ADDR_W'(512);
    end else if (psel && penable && pwrite && pready) begin
      unique case (reg_sel)
        REG_START_OFFSET:   start_offset_q   <= pwdata[ADDR_W-1:0];
        REG_REQUEST_LENGTH: request_length_q <= pwdata[ADDR_W-1:0];
        default: ;
      endcase
    end
  end

  ecs_alu u_alu (
    .op_i  (alu_op),
    .res_o (alu_res)
  );

  ecs_seq u_seq (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid_i),
    .in_ready_o       (in_ready_o),
    .in_data_i        (in_data_i),
    .start_offset_i   (start_offset_q),
    .request_length_i (request_length_q),
    .out_free_i       (out_free),
    .emit_o           (emit),
    .alu_op_o         (alu_op),
    .alu_res_i        (alu_res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (emit.valid) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit.valid) begin
      out_q <= emit.data;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

### hw/rtl/ecs_alu.sv
// Shared 50-bit adder/subtractor of the extent chunk splitter.
// Depends on ecs_pkg for the operand bundle and widths.
module ecs_alu (
  input  ecs_pkg::ecs_alu_op_t     op_i,
  output logic [ecs_pkg::ALU_W-1:0] res_o
);
  import ecs_pkg::*;

  assign res_o = op_i.sub ? (op_i.a - op_i.b) : (op_i.a + op_i.b);

endmodule

### hw/rtl/ecs_seq.sv
// Sequencer and working registers of the extent chunk splitter. It drives the
// shared adder through the setup steps and then one add and one compare per command.
// Depends on ecs_pkg.
module ecs_seq (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  ecs_pkg::ecs_in_t              in_data_i,
  input  logic [ecs_pkg::ADDR_W-1:0]    start_offset_i,
  input  logic [ecs_pkg::ADDR_W-1:0]    request_length_i,
  input  logic                          out_free_i,
  output ecs_pkg::ecs_emit_t            emit_o,
  output ecs_pkg::ecs_alu_op_t          alu_op_o,
  input  logic [ecs_pkg::ALU_W-1:0]     alu_res_i
);
  import ecs_pkg::*;

  ecs_state_e        state_q, state_d;
  ecs_in_t           item_q, item_d;
  logic [ADDR_W-1:0] skip_q, skip_d;
  logic [REM_W-1:0]  rem_q, rem_d;
  logic [LBA_W-1:0]  lba_q, lba_d;
  logic [CNT_W-1:0]  cnt_q, cnt_d;
  logic              fit_q, fit_d;
  logic [CMD_W-1:0]  n_q, n_d;
  logic [PROC_W-1:0] proc_q, proc_d;
  logic              finished_q, finished_d;

  logic [CNT_W-1:0]  cnt_full;
  logic              fits;
  logic              reached;
  logic [EX_W-1:0]   ex;
  logic              ex_ge;
  logic [CNT_W-1:0]  trimmed;
  logic              cmd_last;
  logic [LBA_W-1:0]  lba_next;

  // Sectors left up to the next chunk boundary, and whether the rest fits.
  assign cnt_full = CNT_W'(CHUNK_SECTORS) - CNT_W'(lba_q[CHUNK_SHIFT-1:0]);
  assign fits     = REM_W'(cnt_full) >= rem_q;

  // In the check step the adder holds processed minus request length.
  assign reached  = ~alu_res_i[ALU_W-1];
  assign ex       = alu_res_i[PROC_W-1:SECTOR_SHIFT];
  assign ex_ge    = (|ex[EX_W-1:CNT_W]) || (ex[CNT_W-1:0] >= cnt_q);
  assign trimmed  = (!reached) ? cnt_q : (ex_ge ? '0 : cnt_q - ex[CNT_W-1:0]);
  assign cmd_last = fit_q || reached || (n_q == CMD_W'(MAX_CMDS - 1));
  assign lba_next = {lba_q[LBA_W-1:CHUNK_SHIFT] + (LBA_W-CHUNK_SHIFT)'(1),
                     {CHUNK_SHIFT{1'b0}}};

  assign in_ready_o = (state_q == S_IDLE);

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i && (in_data_i.first_extent || !finished_q)) begin
          state_d = S_SKIP;
        end
      end
      S_SKIP:  state_d = S_EFF;
      S_EFF:   state_d = S_ADDR;
      S_ADDR:  state_d = S_CHUNK;
      S_CHUNK: state_d = (rem_q != '0) ? S_CHECK : S_IDLE;
      S_CHECK: begin
        if (out_free_i) begin
          state_d = cmd_last ? S_IDLE : S_CHUNK;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // Operands of the shared adder for each step.
  always_comb begin
    alu_op_o = '0;
    unique case (state_q)
      S_SKIP: begin
        alu_op_o.a   = ALU_W'(start_offset_i);
        alu_op_o.b   = ALU_W'(item_q.extent_logical);
        alu_op_o.sub = 1'b1;
      end
      S_EFF: begin
        alu_op_o.a   = ALU_W'(item_q.extent_bytes);
        alu_op_o.b   = ALU_W'(skip_q);
        alu_op_o.sub = 1'b1;
      end
      S_ADDR: begin
        alu_op_o.a = ALU_W'(item_q.extent_physical);
        alu_op_o.b = ALU_W'(skip_q);
      end
      S_CHUNK: begin
        alu_op_o.a = ALU_W'(proc_q);
        alu_op_o.b = ALU_W'({(fits ? rem_q[CNT_W-1:0] : cnt_full),
                            {SECTOR_SHIFT{1'b0}}});
      end
      S_CHECK: begin
        alu_op_o.a   = ALU_W'(proc_q);
        alu_op_o.b   = ALU_W'(request_length_i);
        alu_op_o.sub = 1'b1;
      end
      default: ;
    endcase
  end

  always_comb begin
    item_d     = item_q;
    skip_d     = skip_q;
    rem_d      = rem_q;
    lba_d      = lba_q;
    cnt_d      = cnt_q;
    fit_d      = fit_q;
    n_d        = n_q;
    proc_d     = proc_q;
    finished_d = finished_q;
    emit_o     = '0;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          item_d = in_data_i;
          n_d    = '0;
          if (in_data_i.first_extent) begin
            proc_d     = '0;
            finished_d = 1'b0;
          end
        end
      end
      S_SKIP: begin
        // The offset only applies to the first extent, and only when it lies
        // at or beyond the extent's file offset.
        skip_d = (item_q.first_extent && (start_offset_i != '0) && !alu_res_i[ALU_W-1])
               ? alu_res_i[ADDR_W-1:0] : '0;
      end
      S_EFF: begin
        rem_d = alu_res_i[ALU_W-1] ? '0 : alu_res_i[LEN_W-1:SECTOR_SHIFT];
      end
      S_ADDR: begin
        lba_d = alu_res_i[ADDR_W-1:SECTOR_SHIFT];
      end
      S_CHUNK: begin
        if (rem_q != '0) begin
          cnt_d  = fits ? rem_q[CNT_W-1:0] : cnt_full;
          fit_d  = fits;
          rem_d  = rem_q - (fits ? rem_q : REM_W'(cnt_full));
          proc_d = alu_res_i[PROC_W-1:0];
        end
      end
      S_CHECK: begin
        emit_o.valid             = out_free_i;
        emit_o.data.start_lba    = lba_q;
        emit_o.data.num_sectors  = trimmed;
        emit_o.data.extent_end   = cmd_last;
        emit_o.data.request_done = reached;
        if (out_free_i) begin
          lba_d = lba_next;
          n_d   = n_q + CMD_W'(1);
          if (reached) begin
            finished_d = 1'b1;
          end
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_IDLE;
      n_q        <= '0;
      proc_q     <= '0;
      finished_q <= 1'b0;
    end else begin
      state_q    <= state_d;
      n_q        <= n_d;
      proc_q     <= proc_d;
      finished_q <= finished_d;
    end
  end

  always_ff @(posedge clk_i) begin
    item_q <= item_d;
    skip_q <= skip_d;
    rem_q  <= rem_d;
    lba_q  <= lba_d;
    cnt_q  <= cnt_d;
    fit_q  <= fit_d;
  end

endmodule

### hw/rtl/ecs_checker.sv
// Port-level checks for the extent chunk splitter, bound to the top level.
// Depends on ecs_pkg and extent_chunk_splitter_unit.
module ecs_checker (
  input logic              clk_i,
  input logic              rst_ni,
  input logic              in_valid_i,
  input logic              in_ready_o,
  input logic              out_valid_o,
  input logic              out_ready_i,
  input ecs_pkg::ecs_out_t out_data_o
);
  import ecs_pkg::*;

  // A result waiting on the consumer keeps its value.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_data_o))
    else $error("result changed while stalled");

  // The command that completes the request also closes the extent.
  a_done_ends: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.request_done |-> out_data_o.extent_end)
    else $error("request done without extent end");

  // No command crosses a chunk boundary, so none is longer than a chunk.
  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> out_data_o.num_sectors <= CNT_W'(CHUNK_SECTORS))
    else $error("sector count exceeds chunk size");

  // Setup precedes any command, so no result shows right after a request.
  a_no_early: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !$rose(out_valid_o))
    else $error("result appeared one cycle after a request");

endmodule

bind extent_chunk_splitter_unit ecs_checker u_ecs_checker (.*);
